// ===== rtl/core/wquf_pkg.sv =====
// Shared field widths, stream packing and the result bundle of the union-find core.
`default_nettype none
package wquf_pkg;

  // Fixed field widths of the stream payloads
  localparam int unsigned ELEM_W      = 10;
  localparam int unsigned ROOT_W      = 10;
  localparam int unsigned SIZE_W      = 11;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  // Index reduction runs one conditional subtract per shift position
  localparam int unsigned RED_TOP = ELEM_W - 1;
  localparam int unsigned RED_K_W = $clog2(RED_TOP + 1);

  // Result bundle from the sequencer to the output stage
  typedef struct packed {
    logic              connected;
    logic [ROOT_W-1:0] root;
    logic [SIZE_W-1:0] size;
  } wquf_result_t;

endpackage
`default_nettype wire

// ===== rtl/core/wquf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wquf_ram #(
  parameter int unsigned WIDTH = 21,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/wquf_ctrl.sv =====
// Sequencer: clears the forest table, walks both roots one link per cycle, links by size.
`default_nettype none
module wquf_ctrl
  import wquf_pkg::*;
#(
  parameter int unsigned NUM_ELEMENTS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [ELEM_W-1:0] p_elem,
  input  wire logic [ELEM_W-1:0] q_elem,
  output logic                   idle,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output wquf_result_t           res
);

  localparam int unsigned IDX_W    = $clog2(NUM_ELEMENTS);
  localparam int unsigned SZ_W     = $clog2(NUM_ELEMENTS + 1);
  localparam int unsigned ENT_W    = SZ_W + IDX_W;
  localparam bit          NEED_RED = NUM_ELEMENTS < (1 << ELEM_W);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ELEMENTS - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_ISSUE,
    ST_WALK_P,
    ST_WALK_Q,
    ST_DECIDE,
    ST_GROW,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]   clr_r, clr_nxt;
  logic [RED_K_W-1:0] red_k_r, red_k_nxt;
  logic [ELEM_W-1:0]  p_r, p_nxt, q_r, q_nxt;
  logic [IDX_W-1:0]   node_r, node_nxt;
  logic [IDX_W-1:0]   root_p_r, root_p_nxt, root_q_r, root_q_nxt;
  logic [SZ_W-1:0]    size_p_r, size_p_nxt, size_q_r, size_q_nxt;
  logic [IDX_W-1:0]   top_r, top_nxt;
  logic [SZ_W-1:0]    sum_r, sum_nxt;
  wquf_result_t       res_r, res_nxt;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr, rd_addr;
  logic [ENT_W-1:0]   wr_data, rd_data;
  logic [IDX_W-1:0]   rd_parent;
  logic [SZ_W-1:0]    rd_size;
  logic [31:0]        red_thr;
  logic               at_root;
  logic               p_smaller;
  logic [SZ_W-1:0]    size_sum;

  // Forest table: each entry holds {set size, parent link}
  wquf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_ELEMENTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_parent = rd_data[IDX_W-1:0];
  assign rd_size   = rd_data[ENT_W-1:IDX_W];

  // Shared compare and add unit
  assign at_root   = (rd_parent == node_r);
  assign p_smaller = (size_p_r < size_q_r);
  assign size_sum  = size_p_r + size_q_r;
  assign red_thr   = 32'(NUM_ELEMENTS) << red_k_r;

  assign idle      = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;

  // Next state, table access and datapath updates
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    red_k_nxt  = red_k_r;
    p_nxt      = p_r;
    q_nxt      = q_r;
    node_nxt   = node_r;
    root_p_nxt = root_p_r;
    root_q_nxt = root_q_r;
    size_p_nxt = size_p_r;
    size_q_nxt = size_q_r;
    top_nxt    = top_r;
    sum_nxt    = sum_r;
    res_nxt    = res_r;
    wr_en      = 1'b0;
    wr_addr    = clr_r;
    wr_data    = {SZ_W'(1), clr_r};
    rd_addr    = node_r;

    case (state_r)
      ST_CLEAR: begin
        // One entry a cycle: parent is itself, size one
        wr_en   = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          p_nxt     = p_elem;
          q_nxt     = q_elem;
          red_k_nxt = RED_K_W'(RED_TOP);
          state_nxt = NEED_RED ? ST_REDUCE : ST_ISSUE;
        end
      end
      ST_REDUCE: begin
        // Wrap both indices by one conditional subtract per shift position
        if (32'(p_r) >= red_thr) begin
          p_nxt = ELEM_W'(32'(p_r) - red_thr);
        end
        if (32'(q_r) >= red_thr) begin
          q_nxt = ELEM_W'(32'(q_r) - red_thr);
        end
        red_k_nxt = red_k_r - 1'b1;
        if (red_k_r == '0) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        rd_addr   = IDX_W'(p_r);
        node_nxt  = IDX_W'(p_r);
        state_nxt = ST_WALK_P;
      end
      ST_WALK_P: begin
        if (at_root) begin
          root_p_nxt = node_r;
          size_p_nxt = rd_size;
          rd_addr    = IDX_W'(q_r);
          node_nxt   = IDX_W'(q_r);
          state_nxt  = ST_WALK_Q;
        end else begin
          rd_addr  = rd_parent;
          node_nxt = rd_parent;
        end
      end
      ST_WALK_Q: begin
        if (at_root) begin
          root_q_nxt = node_r;
          size_q_nxt = rd_size;
          state_nxt  = ST_DECIDE;
        end else begin
          rd_addr  = rd_parent;
          node_nxt = rd_parent;
        end
      end
      ST_DECIDE: begin
        if (root_p_r == root_q_r) begin
          res_nxt.connected = 1'b1;
          res_nxt.root      = ROOT_W'(root_p_r);
          res_nxt.size      = SIZE_W'(size_p_r);
          state_nxt         = ST_DONE;
        end else begin
          // Hang the smaller root under the larger; p wins a tie
          wr_en   = 1'b1;
          sum_nxt = size_sum;
          if (p_smaller) begin
            wr_addr = root_p_r;
            wr_data = {size_p_r, root_q_r};
            top_nxt = root_q_r;
          end else begin
            wr_addr = root_q_r;
            wr_data = {size_q_r, root_p_r};
            top_nxt = root_p_r;
          end
          res_nxt.connected = 1'b0;
          res_nxt.root      = ROOT_W'(p_smaller ? root_q_r : root_p_r);
          res_nxt.size      = SIZE_W'(size_sum);
          state_nxt         = ST_GROW;
        end
      end
      ST_GROW: begin
        // Store the merged size at the surviving root
        wr_en     = 1'b1;
        wr_addr   = top_r;
        wr_data   = {sum_r, top_r};
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, clear counter and registered datapath
  always_ff @(posedge clk) begin
    red_k_r  <= red_k_nxt;
    p_r      <= p_nxt;
    q_r      <= q_nxt;
    node_r   <= node_nxt;
    root_p_r <= root_p_nxt;
    root_q_r <= root_q_nxt;
    size_p_r <= size_p_nxt;
    size_q_r <= size_q_nxt;
    top_r    <= top_nxt;
    sum_r    <= sum_nxt;
    res_r    <= res_nxt;
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/weighted_quick_union_find_core.sv =====
// Top level of the weighted quick-union disjoint-set core with its output register.
//
//   channel | direction | tdata fields (lowest bit up)
//   --------+-----------+----------------------------------------------------
//   in_     | slave     | p_elem[9:0], q_elem[19:10], zero fill [23:20]
//   out_    | master    | already_connected[0], merged_root[10:1],
//           |           | merged_size[21:11], zero fill [23:22]
//
// After reset the element table is cleared one entry per cycle, while in_tready
// stays low. A pair passes ISSUE, WALK_P, WALK_Q, DECIDE and DONE to out_tvalid,
// through GROW as well when the sets merge, and first through an index wrap
// (REDUCE) when NUM_ELEMENTS is below 1024.
// The root walks read one parent link per cycle from the table's single read
// port. A new pair is taken once the result has moved into the output register;
// a stalled out_tready holds the result and then the core.
`default_nettype none
module weighted_quick_union_find_core
  import wquf_pkg::*;
#(
  parameter int unsigned NUM_ELEMENTS = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // p_elem, q_elem
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata   // already_connected, merged_root, merged_size
);

  logic         core_idle;
  logic         res_valid;
  logic         res_ready;
  wquf_result_t res;
  logic         out_valid_r, out_valid_nxt;
  wquf_result_t out_res_r, out_res_nxt;

  assign in_tready = core_idle;

  wquf_ctrl #(
    .NUM_ELEMENTS (NUM_ELEMENTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_tvalid & core_idle),
    .p_elem    (in_tdata[ELEM_W-1:0]),
    .q_elem    (in_tdata[2*ELEM_W-1:ELEM_W]),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Load the output register when it is empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Pack the beat, lowest field first
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - 1 - ROOT_W - SIZE_W)'(0),
                       out_res_r.size, out_res_r.root, out_res_r.connected};

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Stream testbench for the weighted quick-union core, checked against a union-by-size predictor.
`timescale 1ns / 100ps

module testbench;
  import wquf_pkg::*;

  localparam int unsigned NODES       = 1024;
  localparam int unsigned RESET_TICKS = 12;
  localparam int unsigned IDLE_LIMIT  = 5000;
  localparam int unsigned DRAIN_TICKS = 40;
  localparam int unsigned RAND_PAIRS  = 528;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // p_elem, q_elem
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // already_connected, merged_root, merged_size

  weighted_quick_union_find_core #(
    .NUM_ELEMENTS(NODES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #10 clk = ~clk;

  // Directed pair with an optional hand-typed result
  typedef struct {
    logic [ELEM_W-1:0] p;
    logic [ELEM_W-1:0] q;
    bit                typed;
    logic              conn;
    logic [ROOT_W-1:0] root;
    logic [SIZE_W-1:0] size;
  } pair_row_t;

  // Shadow forest: parent link and set weight per element
  logic [ELEM_W-1:0] link_of   [NODES];
  logic [SIZE_W-1:0] weight_of [NODES];

  wquf_result_t      pending_results[$];
  int unsigned       mismatches = 0;
  int unsigned       idle_ticks = 0;
  bit                ready_calm = 1'b0;
  int unsigned       ready_hold = 0;
  bit                send_calm  = 1'b0;
  logic [ELEM_W-1:0] recent_elems[16];
  int unsigned       recent_wr = 0;

  // Follow parent links up to the root; forests only, so the bound never bites
  function automatic logic [ELEM_W-1:0] root_of(input logic [ELEM_W-1:0] node);
    int unsigned hops;
    hops = 0;
    while (link_of[node] != node && hops < NODES) begin
      node = link_of[node];
      hops++;
    end
    return node;
  endfunction

  // Union by size; on a tie the root of p wins
  function automatic wquf_result_t merge_pair(input logic [ELEM_W-1:0] p,
                                              input logic [ELEM_W-1:0] q);
    logic [ELEM_W-1:0] rp;
    logic [ELEM_W-1:0] rq;
    wquf_result_t      res;
    rp = root_of(p);
    rq = root_of(q);
    res.connected = 1'b0;
    if (rp == rq) begin
      res.connected = 1'b1;
      res.root      = rp;
    end else if (weight_of[rp] < weight_of[rq]) begin
      link_of[rp]   = rq;
      weight_of[rq] = weight_of[rq] + weight_of[rp];
      res.root      = rq;
    end else begin
      link_of[rq]   = rp;
      weight_of[rp] = weight_of[rp] + weight_of[rq];
      res.root      = rp;
    end
    res.size = weight_of[res.root];
    return res;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 80) return $urandom_range(3, 1);
    return $urandom_range(60, 8);
  endfunction

  // Present one pair, hold it until taken, then log its expected result
  task automatic send_pair(input logic [ELEM_W-1:0] p, input logic [ELEM_W-1:0] q,
                           input bit typed, input wquf_result_t typed_res);
    int unsigned  gap;
    wquf_result_t res;
    gap = 0;
    if (!send_calm && $urandom_range(99) < 40) gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - 2 * ELEM_W){1'b0}}, q, p};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = merge_pair(p, q);
    if (typed) res = typed_res;
    pending_results.push_back(res);
    recent_elems[recent_wr % 16] = p;
    recent_elems[(recent_wr + 1) % 16] = q;
    recent_wr += 2;
  endtask

  // Sink side: random stalls, with calm stretches of full throughput
  always @(posedge clk) begin
    if ($urandom_range(149) == 0) ready_calm <= ~ready_calm;
    if (ready_hold > 0) begin
      out_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (!ready_calm && $urandom_range(99) < 30) begin
      out_tready <= 1'b0;
      ready_hold <= gap_len() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest expectation
  wquf_result_t      exp_res;
  logic              got_conn;
  logic [ROOT_W-1:0] got_root;
  logic [SIZE_W-1:0] got_size;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_conn = out_tdata[0];
      got_root = out_tdata[ROOT_W:1];
      got_size = out_tdata[ROOT_W+SIZE_W:ROOT_W+1];
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: tdata=%h", out_tdata);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        if (got_conn !== exp_res.connected) begin
          $error("already_connected: expected %0d, got %0d", exp_res.connected, got_conn);
          mismatches++;
        end
        if (got_root !== exp_res.root) begin
          $error("merged_root: expected %0d, got %0d", exp_res.root, got_root);
          mismatches++;
        end
        if (got_size !== exp_res.size) begin
          $error("merged_size: expected %0d, got %0d", exp_res.size, got_size);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either side (covers the clearing pass)
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_ticks <= 0;
    end else if (idle_ticks >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_ticks <= idle_ticks + 1;
    end
  end

  pair_row_t         directed[$];
  wquf_result_t      row_res;
  int unsigned       cluster_base;
  int unsigned       mode;
  logic [ELEM_W-1:0] rp_sel;
  logic [ELEM_W-1:0] rq_sel;

  initial begin
    directed = '{
      '{10'd5,    10'd5,    1, 1'b1, 10'd5,   11'd1},  // same element, fresh set
      '{10'd0,    10'd1023, 1, 1'b0, 10'd0,   11'd2},  // extremes, tie goes to p
      '{10'd1023, 10'd0,    1, 1'b1, 10'd0,   11'd2},  // already joined
      '{10'd1023, 10'd1023, 1, 1'b1, 10'd0,   11'd2},
      '{10'd1,    10'd2,    1, 1'b0, 10'd1,   11'd2},
      '{10'd3,    10'd1,    0, 1'b0, 10'd0,   11'd0},  // smaller p goes under q
      '{10'd2,    10'd4,    0, 1'b0, 10'd0,   11'd0},  // smaller q goes under p
      '{10'd1023, 10'd3,    0, 1'b0, 10'd0,   11'd0},
      '{10'd682,  10'd341,  1, 1'b0, 10'd682, 11'd2},  // alternating bit patterns
      '{10'd341,  10'd1023, 0, 1'b0, 10'd0,   11'd0},
      '{10'd512,  10'd511,  1, 1'b0, 10'd512, 11'd2},
      '{10'd511,  10'd512,  1, 1'b1, 10'd512, 11'd2},
      '{10'd100,  10'd101,  1, 1'b0, 10'd100, 11'd2},
      '{10'd102,  10'd103,  1, 1'b0, 10'd102, 11'd2},
      '{10'd100,  10'd103,  0, 1'b0, 10'd0,   11'd0},
      '{10'd104,  10'd105,  1, 1'b0, 10'd104, 11'd2},
      '{10'd106,  10'd107,  1, 1'b0, 10'd106, 11'd2},
      '{10'd104,  10'd107,  0, 1'b0, 10'd0,   11'd0},
      '{10'd101,  10'd106,  0, 1'b0, 10'd0,   11'd0},  // equal sizes of four
      '{10'd1023, 10'd107,  0, 1'b0, 10'd0,   11'd0},  // deep walks on both sides
      '{10'd107,  10'd1023, 0, 1'b0, 10'd0,   11'd0},
      '{10'd0,    10'd0,    0, 1'b0, 10'd0,   11'd0}
    };

    for (int unsigned k = 0; k < NODES; k++) begin
      link_of[k]   = k[ELEM_W-1:0];
      weight_of[k] = 11'd1;
    end
    for (int unsigned k = 0; k < 16; k++) recent_elems[k] = '0;

    repeat (RESET_TICKS) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows
    foreach (directed[i]) begin
      row_res.connected = directed[i].conn;
      row_res.root      = directed[i].root;
      row_res.size      = directed[i].size;
      send_pair(directed[i].p, directed[i].q, directed[i].typed, row_res);
    end

    // Random pairs: mostly inside a sliding window so sets grow deep
    cluster_base = $urandom_range(NODES - 64);
    for (int unsigned n = 0; n < RAND_PAIRS; n++) begin
      if (n % 40 == 0) cluster_base = $urandom_range(NODES - 64);
      if ($urandom_range(59) == 0) send_calm = ~send_calm;
      if (n == RAND_PAIRS / 2) begin
        // Let the core drain completely before continuing
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      mode = $urandom_range(99);
      if (mode < 55) begin
        rp_sel = ELEM_W'(cluster_base + $urandom_range(63));
        rq_sel = ELEM_W'(cluster_base + $urandom_range(63));
      end else if (mode < 70) begin
        rp_sel = ELEM_W'($urandom_range(NODES - 1));
        rq_sel = ELEM_W'($urandom_range(NODES - 1));
      end else if (mode < 85) begin
        rp_sel = recent_elems[$urandom_range(15)];
        rq_sel = recent_elems[$urandom_range(15)];
      end else if (mode < 95) begin
        rp_sel = ELEM_W'($urandom_range(NODES - 1));
        rq_sel = rp_sel;
      end else begin
        rp_sel = $urandom_range(1) ? 10'd1023 : 10'd0;
        rq_sel = $urandom_range(1) ? 10'd1023 : ELEM_W'($urandom_range(NODES - 1));
      end
      send_pair(rp_sel, rq_sel, 1'b0, row_res);
    end
    in_tvalid <= 1'b0;

    // Drain, then settle
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
